// ===== src/fha_pkg.sv =====
`timescale 1ns / 1ps

package fha_pkg;

  localparam int unsigned ReqW     = 17;
  localparam int unsigned OffPortW = 16;
  // Rounded request: a 17-bit request plus up to one granule.
  localparam int unsigned WantW    = 18;
  localparam int unsigned HdrBytes = 8;
  localparam int unsigned HdrShift = 3;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_HEAD,
    ST_MERGE,
    ST_SPLIT,
    ST_FREE,
    ST_RESP
  } walk_state_e;

  typedef struct packed {
    logic [OffPortW-1:0] data_offset;
    logic                success;
  } res_t;

endpackage

// ===== src/first_fit_heap_allocator.sv =====
`timescale 1ns / 1ps

// Channel | Direction | Handshake            | Beat fields
// in      | input     | in_valid_i/in_stall_o   | operation_i, request_bytes_i, block_offset_i
// out     | output    | out_valid_o/out_stall_i | data_offset_o, success_o
//
// One beat at a time. Free reads the header, then clears its used bit; an invalid free
// goes straight to the response. Allocate rounds the request, reads headers from slot 0,
// and adds a step per block walked past, per free neighbor merged, per merged run closed
// at a used block, and for a split; a non-power-of-two granule adds a multiply step to
// rounding. The single header read port sets the walk rate.
// Reset needs no clearing pass: only slot 0 carries a flag.
// A held result sits in the output register while the next beat is taken.

module first_fit_heap_allocator
  import fha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES    = 65536,
  parameter int unsigned GRANULE_BYTES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [ReqW-1:0]     request_bytes_i,
  input  logic [OffPortW-1:0] block_offset_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [OffPortW-1:0] data_offset_o,
  output logic                success_o
);

  logic res_valid;
  logic res_ready;
  res_t res;
  logic out_valid_q;
  res_t out_res_q;

  fha_walk #(
    .HEAP_BYTES   (HEAP_BYTES),
    .GRANULE_BYTES(GRANULE_BYTES)
  ) u_walk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .request_bytes_i(request_bytes_i),
    .block_offset_i (block_offset_i),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res)
  );

  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign data_offset_o = out_res_q.data_offset;
  assign success_o     = out_res_q.success;

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("walker took a beat and did not go busy");

  a_idle_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !res_valid)
    else $error("walker idle with a result pending");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("pending result dropped or changed");

  a_fail_zero_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !success_o |-> data_offset_o == '0)
    else $error("failed result carries an offset");

endmodule

// ===== src/fha_round.sv =====
`timescale 1ns / 1ps

module fha_round
  import fha_pkg::*;
#(
  parameter int unsigned GRANULE_BYTES = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [ReqW-1:0]  req_i,
  output logic             done_o,
  output logic [WantW-1:0] want_o
);

  localparam bit GranPow2 = ((GRANULE_BYTES & (GRANULE_BYTES - 1)) == 0);

  if (GranPow2) begin : g_pow2
    localparam logic [WantW-1:0] GMask = WantW'(GRANULE_BYTES - 1);

    logic             done_q;
    logic [WantW-1:0] want_q;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        want_q <= (WantW'(req_i) + GMask) & ~GMask;
      end
    end

    assign done_o = done_q;
    assign want_o = want_q;
  end else begin : g_recip
    // Divide by the granule with a reciprocal multiply, exact for every
    // WantW-bit dividend; scale the quotient back up in the next cycle.
    localparam int unsigned LogG  = $clog2(GRANULE_BYTES);
    localparam int unsigned Sh    = WantW + LogG;
    localparam int unsigned RecW  = WantW + 1;
    localparam int unsigned ProdW = WantW + RecW;
    localparam int unsigned QuotW = ProdW - Sh;
    localparam longint unsigned RecipVal =
      ((longint'(1) << Sh) + longint'(GRANULE_BYTES) - 1) / longint'(GRANULE_BYTES);
    localparam logic [RecW-1:0] Recip = RecW'(RecipVal);

    logic             stage_q;
    logic             done_q;
    logic [WantW-1:0] bump;
    logic [ProdW-1:0] prod;
    logic [QuotW-1:0] quot_q;
    logic [WantW-1:0] want_q;

    assign bump = WantW'(req_i) + WantW'(GRANULE_BYTES - 1);
    assign prod = ProdW'(bump) * ProdW'(Recip);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        stage_q <= 1'b0;
        done_q  <= 1'b0;
      end else begin
        stage_q <= start_i;
        done_q  <= stage_q;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        quot_q <= prod[ProdW-1:Sh];
      end
      if (stage_q) begin
        want_q <= WantW'(quot_q) * WantW'(GRANULE_BYTES);
      end
    end

    assign done_o = done_q;
    assign want_o = want_q;
  end

endmodule

// ===== src/fha_walk.sv =====
`timescale 1ns / 1ps

module fha_walk
  import fha_pkg::*;
#(
  parameter int unsigned HEAP_BYTES    = 65536,
  parameter int unsigned GRANULE_BYTES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                operation_i,
  input  logic [ReqW-1:0]     request_bytes_i,
  input  logic [OffPortW-1:0] block_offset_i,
  output logic                res_valid_o,
  input  logic                res_ready_i,
  output res_t                res_o
);

  localparam int unsigned SlotCount = HEAP_BYTES / HdrBytes;
  localparam int unsigned SlotW     = $clog2(SlotCount);
  localparam int unsigned SzW       = $clog2(HEAP_BYTES);
  localparam int unsigned EntW      = SzW + 1;
  localparam int unsigned OffW      = SzW + 1;
  localparam int unsigned CmpW      = ((OffW > WantW) ? OffW : WantW) + 1;
  localparam int unsigned BoffW     = ((OffW > OffPortW) ? OffW : OffPortW) + 1;
  localparam logic [OffW-1:0] EndOff     = OffW'(HEAP_BYTES);
  localparam logic [EntW-1:0] Slot0Reset = {SzW'(HEAP_BYTES - HdrBytes), 1'b0};

  walk_state_e state_q, state_d;

  logic [OffW-1:0]  at_q, at_d;
  logic [OffW-1:0]  nxt_q, nxt_d;
  logic [SzW-1:0]   cur_sz_q, cur_sz_d;
  logic [SlotW-1:0] wslot_q, wslot_d;
  logic [SzW-1:0]   tail_sz_q, tail_sz_d;
  logic [CmpW-1:0]  need_q, need_d;
  res_t             res_q, res_d;

  // Header store
  logic [EntW-1:0]  hdr_mem [SlotCount];
  logic             mem_we;
  logic [SlotW-1:0] mem_waddr;
  logic [EntW-1:0]  mem_wdata;
  logic             mem_re;
  logic [SlotW-1:0] mem_raddr;
  logic [EntW-1:0]  rd_q;
  logic             rd_rst_q;
  logic             slot0_vld_q;

  logic             round_start;
  logic             round_done;
  logic [WantW-1:0] want;

  logic             free_ok;
  logic [BoffW-1:0] boff_ext;
  logic [BoffW-1:0] boff_hdr;
  logic [SlotW-1:0] free_slot;
  logic [EntW-1:0]  rd_ent;
  logic [SzW-1:0]   rd_sz;
  logic             rd_used;
  logic             fits;
  logic             split;
  logic [OffW-1:0]  head_nxt;
  logic             head_end;
  logic [OffW-1:0]  split_off;
  logic [OffW-1:0]  mrg_sum;
  logic [SzW-1:0]   mrg_sz;
  logic [OffW-1:0]  mrg_nxt;
  logic             mrg_end;

  fha_round #(
    .GRANULE_BYTES(GRANULE_BYTES)
  ) u_round (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(round_start),
    .req_i  (request_bytes_i),
    .done_o (round_done),
    .want_o (want)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      hdr_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q     <= hdr_mem[mem_raddr];
      rd_rst_q <= (mem_raddr == '0) && !slot0_vld_q;
    end
  end

  // Only slot 0 carries a reset flag: the walk reaches no other slot that it has not itself
  // written, but a free reads whichever slot block_offset_i names, written or not.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot0_vld_q <= 1'b0;
    end else if (mem_we && (mem_waddr == '0)) begin
      slot0_vld_q <= 1'b1;
    end
  end

  assign rd_ent  = rd_rst_q ? Slot0Reset : rd_q;
  assign rd_sz   = rd_ent[EntW-1:1];
  assign rd_used = rd_ent[0];

  assign boff_ext  = BoffW'(block_offset_i);
  assign boff_hdr  = boff_ext - BoffW'(HdrBytes);
  assign free_ok   = (block_offset_i >= OffPortW'(HdrBytes)) &&
                     (block_offset_i[HdrShift-1:0] == '0) &&
                     (boff_hdr < BoffW'(HEAP_BYTES));
  assign free_slot = SlotW'(boff_hdr >> HdrShift);

  assign fits      = !rd_used && (CmpW'(rd_sz) >= CmpW'(want));
  assign split     = CmpW'(rd_sz) > need_q;
  assign head_nxt  = at_q + OffW'(HdrBytes) + OffW'(rd_sz);
  assign head_end  = head_nxt >= EndOff;
  assign split_off = at_q + OffW'(HdrBytes) + OffW'(want);

  // The next header follows the absorbed block, so it is found from nxt_q and that block's size.
  assign mrg_sum = OffW'(cur_sz_q) + OffW'(HdrBytes) + OffW'(rd_sz);
  assign mrg_sz  = mrg_sum[SzW-1:0];
  assign mrg_nxt = nxt_q + OffW'(HdrBytes) + OffW'(rd_sz);
  assign mrg_end = mrg_nxt >= EndOff;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (operation_i == OP_ALLOC) begin
            state_d = ST_ROUND;
          end else begin
            state_d = free_ok ? ST_FREE : ST_RESP;
          end
        end
      end
      ST_ROUND: begin
        if (round_done) begin
          state_d = ST_HEAD;
        end
      end
      ST_HEAD: begin
        priority if (fits) begin
          state_d = split ? ST_SPLIT : ST_RESP;
        end else if (head_end) begin
          state_d = ST_RESP;
        end else if (rd_used) begin
          state_d = ST_HEAD;
        end else begin
          state_d = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (!rd_used) begin
          state_d = mrg_end ? ST_RESP : ST_MERGE;
        end else begin
          state_d = ST_HEAD;
        end
      end
      ST_SPLIT: state_d = ST_RESP;
      ST_FREE:  state_d = ST_RESP;
      ST_RESP: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    at_d        = at_q;
    nxt_d       = nxt_q;
    cur_sz_d    = cur_sz_q;
    wslot_d     = wslot_q;
    tail_sz_d   = tail_sz_q;
    need_d      = need_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    mem_waddr   = '0;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    round_start = 1'b0;
    in_stall_o  = (state_q != ST_IDLE);
    res_valid_o = (state_q == ST_RESP);

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          res_d = '0;
          if (operation_i == OP_ALLOC) begin
            round_start = 1'b1;
          end else if (free_ok) begin
            mem_re    = 1'b1;
            mem_raddr = free_slot;
            wslot_d   = free_slot;
          end
        end
      end
      ST_ROUND: begin
        if (round_done) begin
          mem_re    = 1'b1;
          mem_raddr = '0;
          at_d      = '0;
          need_d    = CmpW'(want) + CmpW'(HdrBytes);
        end
      end
      ST_HEAD: begin
        if (fits) begin
          mem_we    = 1'b1;
          mem_waddr = at_q[HdrShift +: SlotW];
          mem_wdata = split ? {SzW'(want), 1'b1} : (rd_ent | EntW'(1));
          wslot_d   = split_off[HdrShift +: SlotW];
          tail_sz_d = SzW'(CmpW'(rd_sz) - need_q);
          res_d.data_offset = OffPortW'(at_q + OffW'(HdrBytes));
          res_d.success     = 1'b1;
        end else if (!head_end) begin
          mem_re    = 1'b1;
          mem_raddr = head_nxt[HdrShift +: SlotW];
          if (rd_used) begin
            at_d = head_nxt;
          end else begin
            nxt_d    = head_nxt;
            cur_sz_d = rd_sz;
          end
        end
      end
      ST_MERGE: begin
        if (!rd_used) begin
          cur_sz_d = mrg_sz;
          if (mrg_end) begin
            mem_we    = 1'b1;
            mem_waddr = at_q[HdrShift +: SlotW];
            mem_wdata = {mrg_sz, 1'b0};
          end else begin
            mem_re    = 1'b1;
            mem_raddr = mrg_nxt[HdrShift +: SlotW];
            nxt_d     = mrg_nxt;
          end
        end else begin
          // Commit the merged run; the used header stays in rd_q for the next look.
          mem_we    = 1'b1;
          mem_waddr = at_q[HdrShift +: SlotW];
          mem_wdata = {cur_sz_q, 1'b0};
          at_d      = nxt_q;
        end
      end
      ST_SPLIT: begin
        mem_we    = 1'b1;
        mem_waddr = wslot_q;
        mem_wdata = {tail_sz_q, 1'b0};
      end
      ST_FREE: begin
        mem_we        = 1'b1;
        mem_waddr     = wslot_q;
        mem_wdata     = rd_ent & ~EntW'(1);
        res_d.success = 1'b1;
      end
      ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    at_q      <= at_d;
    nxt_q     <= nxt_d;
    cur_sz_q  <= cur_sz_d;
    wslot_q   <= wslot_d;
    tail_sz_q <= tail_sz_d;
    need_q    <= need_d;
    res_q     <= res_d;
  end

  assign res_o = res_q;

endmodule
